// File: rtl/assert_macros.svh
// Assertion helpers used by the slicer divider (tpsl_div); empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TPSL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("check failed");
`define TPSL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error("check failed");
`else
`define TPSL_ASSERT(lbl, clk, rst_n, prop)
`define TPSL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/tpsl_pkg.sv
package tpsl_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int CFG_IDX_W       = 3;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_PX = 3'd0,
    CFG_PLANE_PY = 3'd1,
    CFG_PLANE_PZ = 3'd2,
    CFG_NORMAL_X = 3'd3,
    CFG_NORMAL_Y = 3'd4,
    CFG_NORMAL_Z = 3'd5
  } cfg_reg_t;

endpackage

// File: rtl/tpsl_dist.sv
module tpsl_dist #(
  parameter int CW = tpsl_pkg::COORD_WIDTH_DEF,
  parameter int F  = tpsl_pkg::FRAC_BITS_DEF,
  parameter int NW = F + 2,
  parameter int DW = CW + 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [8:0][CW-1:0]       in_vert,
  input  logic [2:0][CW-1:0]       plane,
  input  logic [2:0][NW-1:0]       normal,
  output logic                     out_valid,
  output logic [8:0][CW-1:0]       out_vert,
  output logic [2:0][DW-1:0]       out_f
);

  localparam int PW = CW + 3;

  logic [2:0][2:0][CW:0]   d_diff;
  logic [2:0][2:0][CW:0]   d_mag;
  logic [2:0][2:0]         d_neg;
  logic [2:0][NW-1:0]      n_mag;

  logic                    s1_valid_r;
  logic [8:0][CW-1:0]      s1_vert_r;
  logic [2:0][2:0][CW:0]   s1_mag_r;
  logic [2:0][2:0]         s1_neg_r;
  logic [2:0][NW-1:0]      s1_nmag_r;

  logic [2:0][2:0][CW+NW:0] p_prod;
  logic [2:0][2:0][PW-1:0]  p_term;

  logic                    s2_valid_r;
  logic [8:0][CW-1:0]      s2_vert_r;
  logic [2:0][2:0][PW-1:0] s2_term_r;

  logic [2:0][DW-1:0]      f_sum;

  logic                    s3_valid_r;
  logic [8:0][CW-1:0]      s3_vert_r;
  logic [2:0][DW-1:0]      s3_f_r;

  // form P - V and split into magnitude and product sign
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_mag[k] = normal[k][NW-1] ? NW'(-normal[k]) : normal[k];
      for (int v = 0; v < 3; v++) begin
        d_diff[v][k] = {plane[k][CW-1], plane[k]} - {in_vert[v*3+k][CW-1], in_vert[v*3+k]};
        d_mag[v][k]  = d_diff[v][k][CW] ? (CW+1)'(-d_diff[v][k]) : d_diff[v][k];
        d_neg[v][k]  = d_diff[v][k][CW] ^ normal[k][NW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_vert_r <= in_vert;
      s1_mag_r  <= d_mag;
      s1_neg_r  <= d_neg;
      s1_nmag_r <= n_mag;
    end
  end

  // multiply magnitudes, drop fraction bits toward zero, restore sign
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int k = 0; k < 3; k++) begin
        p_prod[v][k] = (CW+NW+1)'(s1_mag_r[v][k]) * (CW+NW+1)'(s1_nmag_r[k]);
        p_term[v][k] = s1_neg_r[v][k] ? PW'(-p_prod[v][k][F +: PW]) : p_prod[v][k][F +: PW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_vert_r <= s1_vert_r;
      s2_term_r <= p_term;
    end
  end

  // sum the three axis terms per vertex
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      f_sum[v] = DW'($signed(s2_term_r[v][0])) + DW'($signed(s2_term_r[v][1]))
               + DW'($signed(s2_term_r[v][2]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_vert_r <= s2_vert_r;
      s3_f_r    <= f_sum;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_vert  = s3_vert_r;
  assign out_f     = s3_f_r;

endmodule

// File: rtl/tpsl_div.sv
`include "assert_macros.svh"

module tpsl_div #(
  parameter int CW = tpsl_pkg::COORD_WIDTH_DEF,
  parameter int F  = tpsl_pkg::FRAC_BITS_DEF,
  parameter int DW = CW + 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [8:0][CW-1:0]   in_vert,
  input  logic [2:0][DW-1:0]   in_f,
  output logic                 out_valid,
  output logic [8:0][CW-1:0]   out_vert,
  output logic [2:0][F:0]      out_q,
  output logic [2:0]           out_ev,
  output logic                 out_hit
);

  localparam int RW = DW + 1;

  logic [2:0]          e_ev;
  logic [2:0]          e_sat;
  logic [2:0][RW-1:0]  e_num;
  logic [2:0][RW-1:0]  e_den;
  logic [2:0]          v_pos;
  logic                e_hit;

  logic [F:0]                 st_valid_r;
  logic [F:0]                 st_hit_r;
  logic [F:0][8:0][CW-1:0]    st_vert_r;
  logic [F:0][2:0]            st_ev_r;
  logic [F:0][2:0]            st_sat_r;
  logic [F:0][2:0][RW-1:0]    st_r_r;
  logic [F:0][2:0][RW-1:0]    st_den_r;
  logic [F:0][2:0][F-1:0]     st_q_r;

  // edge setup: edge e runs from vertex e to the next one around the triangle
  for (genvar e = 0; e < 3; e++) begin : g_edge
    localparam int WI = (e + 1) % 3;
    logic [DW:0] df;
    always_comb begin
      df       = {in_f[WI][DW-1], in_f[WI]} - {in_f[e][DW-1], in_f[e]};
      e_num[e] = in_f[WI][DW-1] ? RW'(-{in_f[WI][DW-1], in_f[WI]})
                                : RW'({in_f[WI][DW-1], in_f[WI]});
      e_den[e] = df[DW] ? RW'(-df) : RW'(df);
      e_ev[e]  = (in_f[e] != in_f[WI])
               && !($signed(in_f[e]) > 0 && $signed(in_f[WI]) > 0)
               && !($signed(in_f[e]) < 0 && $signed(in_f[WI]) < 0);
      e_sat[e] = e_num[e] >= e_den[e];
    end
    assign v_pos[e] = $signed(in_f[e]) > 0;
  end

  // crossing when some but not all distances are positive
  assign e_hit = (v_pos != 3'b000) && (v_pos != 3'b111);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r[0] <= 1'b0;
    end else if (en) begin
      st_valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_hit_r[0]  <= e_hit;
      st_vert_r[0] <= in_vert;
      st_ev_r[0]   <= e_ev;
      st_sat_r[0]  <= e_sat;
      st_r_r[0]    <= e_num;
      st_den_r[0]  <= e_den;
      st_q_r[0]    <= '0;
    end
  end

  // one restoring division step per stage
  for (genvar j = 1; j <= F; j++) begin : g_step
    logic [2:0][RW:0]   r2;
    logic [2:0]         ge;
    logic [2:0][RW-1:0] r_nxt;
    logic [2:0][F-1:0]  q_nxt;

    always_comb begin
      for (int e = 0; e < 3; e++) begin
        r2[e]    = {st_r_r[j-1][e], 1'b0};
        ge[e]    = r2[e] >= {1'b0, st_den_r[j-1][e]};
        r_nxt[e] = ge[e] ? RW'(r2[e] - {1'b0, st_den_r[j-1][e]}) : RW'(r2[e]);
        q_nxt[e] = {st_q_r[j-1][e][F-2:0], ge[e]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_valid_r[j] <= 1'b0;
      end else if (en) begin
        st_valid_r[j] <= st_valid_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_hit_r[j]  <= st_hit_r[j-1];
        st_vert_r[j] <= st_vert_r[j-1];
        st_ev_r[j]   <= st_ev_r[j-1];
        st_sat_r[j]  <= st_sat_r[j-1];
        st_den_r[j]  <= st_den_r[j-1];
        st_r_r[j]    <= r_nxt;
        st_q_r[j]    <= q_nxt;
      end
    end
  end

  // vertex e (U) lying on the plane gives full weight
  always_comb begin
    for (int e = 0; e < 3; e++) begin
      out_q[e] = st_sat_r[F][e] ? ((F+1)'(1) << F) : {1'b0, st_q_r[F][e]};
    end
  end

  assign out_valid = st_valid_r[F];
  assign out_vert  = st_vert_r[F];
  assign out_ev    = st_ev_r[F];
  assign out_hit   = st_hit_r[F];

  for (genvar e = 0; e < 3; e++) begin : g_chk
    `TPSL_ASSERT_IMPL(a_num_le_den, clk, rst_n, st_valid_r[0] && st_ev_r[0][e], st_r_r[0][e] <= st_den_r[0][e])
    `TPSL_ASSERT_IMPL(a_sat_on_plane, clk, rst_n, st_valid_r[0] && st_ev_r[0][e] && st_sat_r[0][e], st_r_r[0][e] == st_den_r[0][e])
    `TPSL_ASSERT_IMPL(a_rem_lt_den, clk, rst_n, st_valid_r[F] && st_ev_r[F][e] && !st_sat_r[F][e], st_r_r[F][e] < st_den_r[F][e])
  end

endmodule

// File: rtl/tpsl_interp.sv
module tpsl_interp #(
  parameter int CW = tpsl_pkg::COORD_WIDTH_DEF,
  parameter int F  = tpsl_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [8:0][CW-1:0]   in_vert,
  input  logic [2:0][F:0]      in_q,
  input  logic [2:0]           in_ev,
  input  logic                 in_hit,
  output logic                 out_valid,
  output logic [2:0][CW-1:0]   out_seg0,
  output logic [2:0][CW-1:0]   out_seg1
);

  localparam int TW = CW + 2;

  logic [2:0][2:0][CW:0]     i_diff;
  logic [2:0][2:0][CW:0]     i_mag;

  logic                      s1_valid_r;
  logic                      s1_hit_r;
  logic [2:0]                s1_ev_r;
  logic [2:0][F:0]           s1_q_r;
  logic [2:0][2:0][CW:0]     s1_mag_r;
  logic [2:0][2:0]           s1_neg_r;
  logic [2:0][2:0][CW-1:0]   s1_base_r;

  logic [2:0][2:0][CW+F+1:0] m_prod;
  logic [2:0][2:0][TW-1:0]   m_term;

  logic                      s2_valid_r;
  logic                      s2_hit_r;
  logic [2:0]                s2_ev_r;
  logic [2:0][2:0][TW-1:0]   s2_term_r;
  logic [2:0][2:0][CW-1:0]   s2_base_r;

  logic [2:0][2:0][CW-1:0]   pt;
  logic [2:0][CW-1:0]        seg0_nxt;
  logic [2:0][CW-1:0]        seg1_nxt;

  logic                      out_valid_r;
  logic [2:0][CW-1:0]        seg0_r;
  logic [2:0][CW-1:0]        seg1_r;

  // edge e: U is vertex e, W is the next vertex; form U - W
  always_comb begin
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        i_diff[e][k] = {in_vert[e*3+k][CW-1], in_vert[e*3+k]}
                     - {in_vert[((e == 2) ? 0 : e*3+3)+k][CW-1],
                        in_vert[((e == 2) ? 0 : e*3+3)+k]};
        i_mag[e][k]  = i_diff[e][k][CW] ? (CW+1)'(-i_diff[e][k]) : i_diff[e][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_hit_r <= in_hit;
      s1_ev_r  <= in_ev;
      s1_q_r   <= in_q;
      s1_mag_r <= i_mag;
      for (int e = 0; e < 3; e++) begin
        for (int k = 0; k < 3; k++) begin
          s1_neg_r[e][k]  <= i_diff[e][k][CW];
          s1_base_r[e][k] <= in_vert[((e == 2) ? 0 : e*3+3)+k];
        end
      end
    end
  end

  // scale the edge vector by the weight, truncate toward zero
  always_comb begin
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        m_prod[e][k] = (CW+F+2)'(s1_mag_r[e][k]) * (CW+F+2)'(s1_q_r[e]);
        m_term[e][k] = s1_neg_r[e][k] ? TW'(-m_prod[e][k][F +: TW])
                                      : m_prod[e][k][F +: TW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_hit_r  <= s1_hit_r;
      s2_ev_r   <= s1_ev_r;
      s2_term_r <= m_term;
      s2_base_r <= s1_base_r;
    end
  end

  // add to W, then pick the first and second crossing in edge order
  always_comb begin
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        pt[e][k] = CW'(TW'($signed(s2_base_r[e][k])) + s2_term_r[e][k]);
      end
    end
    if (s2_ev_r[0]) begin
      seg0_nxt = pt[0];
    end else if (s2_ev_r[1]) begin
      seg0_nxt = pt[1];
    end else if (s2_ev_r[2]) begin
      seg0_nxt = pt[2];
    end else begin
      seg0_nxt = '0;
    end
    if (s2_ev_r[0] && s2_ev_r[1]) begin
      seg1_nxt = pt[1];
    end else if ((s2_ev_r[0] || s2_ev_r[1]) && s2_ev_r[2]) begin
      seg1_nxt = pt[2];
    end else begin
      seg1_nxt = seg0_nxt;
    end
  end

  // output register: drop triangles that do not cross
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s2_valid_r && s2_hit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg0_r <= seg0_nxt;
      seg1_r <= seg1_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_seg0  = seg0_r;
  assign out_seg1  = seg1_r;

endmodule

// File: rtl/triangle_plane_slice_unit.sv
// Triangle/plane slicer. Each beat on the in_ channel carries one triangle;
// the block forms the signed distance of each vertex to the configured plane
// and, when the triangle crosses it, returns one beat on the out_ channel
// holding the two segment endpoints (a single crossing is repeated as the
// second endpoint). Triangles that do not cross produce no beat. One triangle
// is taken every cycle unless held; results pass through the distance stage,
// the bit-per-stage weight divider and interpolation. The whole pipeline holds
// while a finished result is stalled at the output. Program the plane only
// while no triangle is in flight; cfg_ready is always high.
module triangle_plane_slice_unit #(
  parameter int COORD_WIDTH = tpsl_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = tpsl_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_WIDTH-1:0]       in_va_x,
  input  logic signed [COORD_WIDTH-1:0]       in_va_y,
  input  logic signed [COORD_WIDTH-1:0]       in_va_z,
  input  logic signed [COORD_WIDTH-1:0]       in_vb_x,
  input  logic signed [COORD_WIDTH-1:0]       in_vb_y,
  input  logic signed [COORD_WIDTH-1:0]       in_vb_z,
  input  logic signed [COORD_WIDTH-1:0]       in_vc_x,
  input  logic signed [COORD_WIDTH-1:0]       in_vc_y,
  input  logic signed [COORD_WIDTH-1:0]       in_vc_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COORD_WIDTH-1:0]       out_seg0_x,
  output logic signed [COORD_WIDTH-1:0]       out_seg0_y,
  output logic signed [COORD_WIDTH-1:0]       out_seg0_z,
  output logic signed [COORD_WIDTH-1:0]       out_seg1_x,
  output logic signed [COORD_WIDTH-1:0]       out_seg1_y,
  output logic signed [COORD_WIDTH-1:0]       out_seg1_z,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tpsl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_WIDTH-1:0]              cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NW = F + 2;
  localparam int DW = CW + 4;

  logic [2:0][CW-1:0]   plane_r;
  logic [2:0][NW-1:0]   normal_r;
  logic                 en;
  logic [8:0][CW-1:0]   vert_in;

  logic                 d_valid;
  logic [8:0][CW-1:0]   d_vert;
  logic [2:0][DW-1:0]   d_f;

  logic                 q_valid;
  logic [8:0][CW-1:0]   q_vert;
  logic [2:0][F:0]      q_w;
  logic [2:0]           q_ev;
  logic                 q_hit;

  logic [2:0][CW-1:0]   seg0;
  logic [2:0][CW-1:0]   seg1;

  // plane registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r  <= '0;
      normal_r <= {NW'(1) << F, NW'(0), NW'(0)};
    end else if (cfg_valid && cfg_ready) begin
      case (tpsl_pkg::cfg_reg_t'(cfg_index))
        tpsl_pkg::CFG_PLANE_PX: plane_r[0]  <= cfg_data;
        tpsl_pkg::CFG_PLANE_PY: plane_r[1]  <= cfg_data;
        tpsl_pkg::CFG_PLANE_PZ: plane_r[2]  <= cfg_data;
        tpsl_pkg::CFG_NORMAL_X: normal_r[0] <= cfg_data[NW-1:0];
        tpsl_pkg::CFG_NORMAL_Y: normal_r[1] <= cfg_data[NW-1:0];
        tpsl_pkg::CFG_NORMAL_Z: normal_r[2] <= cfg_data[NW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // advance everything unless a result waits at the output
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  assign vert_in = {in_vc_z, in_vc_y, in_vc_x, in_vb_z, in_vb_y, in_vb_x,
                    in_va_z, in_va_y, in_va_x};

  tpsl_dist #(.CW(CW), .F(F), .NW(NW), .DW(DW)) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_vert   (vert_in),
    .plane     (plane_r),
    .normal    (normal_r),
    .out_valid (d_valid),
    .out_vert  (d_vert),
    .out_f     (d_f)
  );

  tpsl_div #(.CW(CW), .F(F), .DW(DW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid),
    .in_vert   (d_vert),
    .in_f      (d_f),
    .out_valid (q_valid),
    .out_vert  (q_vert),
    .out_q     (q_w),
    .out_ev    (q_ev),
    .out_hit   (q_hit)
  );

  tpsl_interp #(.CW(CW), .F(F)) u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (q_valid),
    .in_vert   (q_vert),
    .in_q      (q_w),
    .in_ev     (q_ev),
    .in_hit    (q_hit),
    .out_valid (out_valid),
    .out_seg0  (seg0),
    .out_seg1  (seg1)
  );

  assign out_seg0_x = seg0[0];
  assign out_seg0_y = seg0[1];
  assign out_seg0_z = seg0[2];
  assign out_seg1_x = seg1[0];
  assign out_seg1_y = seg1[1];
  assign out_seg1_z = seg1[2];

endmodule
